// File: rtl/hpbp_pkg.sv
package hpbp_pkg;

    localparam int MAX_CONT_BYTES = 4;
    localparam int FIFO_DEPTH     = 4;
    localparam int PTR_W          = $clog2(FIFO_DEPTH);
    localparam int CNT_W          = $clog2(FIFO_DEPTH + 1);

    localparam logic [2:0] KIND_INDEXED   = 3'd0;
    localparam logic [2:0] KIND_LIT_START = 3'd1;
    localparam logic [2:0] KIND_NAME_START = 3'd2;
    localparam logic [2:0] KIND_NAME_BYTE = 3'd3;
    localparam logic [2:0] KIND_VAL_START = 3'd4;
    localparam logic [2:0] KIND_VAL_BYTE  = 3'd5;
    localparam logic [2:0] KIND_ERROR     = 3'd6;
    localparam logic [2:0] KIND_DONE      = 3'd7;

    localparam logic [1:0] ERR_ZERO_INDEX = 2'd0;
    localparam logic [1:0] ERR_INT_LONG   = 2'd1;
    localparam logic [1:0] ERR_TRUNCATED  = 2'd2;

    typedef struct packed {
        logic [2:0]  out_kind;
        logic [28:0] field_index;
        logic        store_flag;
        logic [28:0] string_length;
        logic        huffman_flag;
        logic [7:0]  data_byte;
        logic        string_last;
        logic [1:0]  error_code;
    } t_result;

    typedef struct packed {
        logic [1:0]    valid;
        t_result [1:0] res;
    } t_push;

endpackage

// File: rtl/hpack_header_block_parser_top.sv
// Byte-serial HPACK header block parser.
// The input channel (i_in_valid / o_in_ready) takes one header block byte per
// request, with i_block_end marking the last byte of a block. The output
// channel (o_out_valid / i_out_ready) delivers one result per request:
// indexed fields, literal starts, string starts and raw string bytes, errors
// and a block done marker.
// Each byte is parsed in the cycle it is accepted and its results are written
// into a four-entry result queue, so a result is registered in the queue before
// it is delivered on the output channel.
// A byte yields at most one result of its own plus one block end result, so
// the block sustains one byte per cycle while the receiver keeps up; the
// last byte of a block also yields a block end result. The queue accepts
// a byte while it has room for two results, which sets the rate on a stall.
// When the receiver stalls, results wait in the queue and o_in_ready drops
// once fewer than two entries are free; nothing is lost.
// Reset returns the parser to the start of a field and empties the queue.
module hpack_header_block_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_block_end,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_out_kind,
    output logic [28:0] o_field_index,
    output logic        o_store_flag,
    output logic [28:0] o_string_length,
    output logic        o_huffman_flag,
    output logic [7:0]  o_data_byte,
    output logic        o_string_last,
    output logic [1:0]  o_error_code
);

    hpbp_pkg::t_push   push;
    hpbp_pkg::t_result result;
    logic              room;
    logic              accept;

    assign o_in_ready = room;
    assign accept     = i_in_valid && room;

    hpbp_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_in_byte   (i_in_byte),
        .i_block_end (i_block_end),
        .o_push      (push)
    );

    hpbp_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_room   (room),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (result)
    );

    assign o_out_kind      = result.out_kind;
    assign o_field_index   = result.field_index;
    assign o_store_flag    = result.store_flag;
    assign o_string_length = result.string_length;
    assign o_huffman_flag  = result.huffman_flag;
    assign o_data_byte     = result.data_byte;
    assign o_string_last   = result.string_last;
    assign o_error_code    = result.error_code;

endmodule

// File: rtl/hpbp_step.sv
module hpbp_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_in_byte,
    input  logic                i_block_end,
    output hpbp_pkg::t_push     o_push
);

    localparam logic [3:0] PH_IDLE          = 4'd0;
    localparam logic [3:0] PH_INDEXED_CONT  = 4'd1;
    localparam logic [3:0] PH_LITIDX_CONT   = 4'd2;
    localparam logic [3:0] PH_NAMELEN_FIRST = 4'd3;
    localparam logic [3:0] PH_NAMELEN_CONT  = 4'd4;
    localparam logic [3:0] PH_NAME_BYTES    = 4'd5;
    localparam logic [3:0] PH_VALLEN_FIRST  = 4'd6;
    localparam logic [3:0] PH_VALLEN_CONT   = 4'd7;
    localparam logic [3:0] PH_VAL_BYTES     = 4'd8;
    localparam logic [3:0] PH_ERROR         = 4'd9;

    logic [3:0]  r_phase, n_phase;
    logic [28:0] r_acc, n_acc;
    logic [4:0]  r_shift, n_shift;
    logic [2:0]  r_cnt, n_cnt;
    logic [28:0] r_remain, n_remain;
    logic        r_store, n_store;
    logic        r_huff, n_huff;

    logic        fin;
    logic [3:0]  fin_ctx;
    logic [28:0] fin_val;
    logic [7:0]  prefix;
    logic [7:0]  pmask;
    logic        last_byte;
    hpbp_pkg::t_result res0, res1;
    logic        v0, v1;

    always_comb begin
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_shift  = r_shift;
        n_cnt    = r_cnt;
        n_remain = r_remain;
        n_store  = r_store;
        n_huff   = r_huff;
        fin      = 1'b0;
        fin_ctx  = PH_IDLE;
        fin_val  = '0;
        prefix   = '0;
        pmask    = '0;
        last_byte = 1'b0;
        res0     = '0;
        res1     = '0;
        v0       = 1'b0;
        v1       = 1'b0;

        unique case (r_phase)
            PH_IDLE, PH_NAMELEN_FIRST, PH_VALLEN_FIRST: begin
                if (r_phase == PH_IDLE) begin
                    if (i_in_byte[7]) begin
                        n_store = 1'b0;
                        pmask   = 8'h7F;
                        fin_ctx = PH_INDEXED_CONT;
                    end else if (i_in_byte[6]) begin
                        n_store = 1'b1;
                        pmask   = 8'h3F;
                        fin_ctx = PH_LITIDX_CONT;
                    end else begin
                        n_store = 1'b0;
                        pmask   = 8'h0F;
                        fin_ctx = PH_LITIDX_CONT;
                    end
                end else begin
                    n_huff  = i_in_byte[7];
                    pmask   = 8'h7F;
                    fin_ctx = (r_phase == PH_NAMELEN_FIRST) ? PH_NAMELEN_CONT
                                                            : PH_VALLEN_CONT;
                end
                prefix  = i_in_byte & pmask;
                n_acc   = 29'(prefix);
                n_shift = '0;
                n_cnt   = '0;
                fin_val = 29'(prefix);
                if (prefix == pmask) begin
                    n_phase = fin_ctx;
                end else begin
                    fin = 1'b1;
                end
            end
            PH_INDEXED_CONT, PH_LITIDX_CONT, PH_NAMELEN_CONT, PH_VALLEN_CONT: begin
                n_acc   = r_acc + (29'(i_in_byte[6:0]) << r_shift);
                n_cnt   = r_cnt + 3'd1;
                fin_ctx = r_phase;
                fin_val = n_acc;
                if (i_in_byte[7]) begin
                    if (n_cnt >= 3'(hpbp_pkg::MAX_CONT_BYTES)) begin
                        v0              = 1'b1;
                        res0.out_kind   = hpbp_pkg::KIND_ERROR;
                        res0.error_code = hpbp_pkg::ERR_INT_LONG;
                        n_phase         = PH_ERROR;
                    end else begin
                        n_shift = r_shift + 5'd7;
                    end
                end else begin
                    fin = 1'b1;
                end
            end
            PH_NAME_BYTES, PH_VAL_BYTES: begin
                last_byte        = (r_remain <= 29'd1);
                v0               = 1'b1;
                res0.out_kind    = (r_phase == PH_NAME_BYTES) ? hpbp_pkg::KIND_NAME_BYTE
                                                              : hpbp_pkg::KIND_VAL_BYTE;
                res0.data_byte   = i_in_byte;
                res0.string_last = last_byte;
                n_remain         = r_remain - 29'd1;
                if (last_byte) begin
                    n_phase = (r_phase == PH_NAME_BYTES) ? PH_VALLEN_FIRST : PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_ERROR;
            end
        endcase

        if (fin) begin
            v0 = 1'b1;
            unique case (fin_ctx)
                PH_INDEXED_CONT: begin
                    if (fin_val == '0) begin
                        res0.out_kind   = hpbp_pkg::KIND_ERROR;
                        res0.error_code = hpbp_pkg::ERR_ZERO_INDEX;
                        n_phase         = PH_ERROR;
                    end else begin
                        res0.out_kind    = hpbp_pkg::KIND_INDEXED;
                        res0.field_index = fin_val;
                        n_phase          = PH_IDLE;
                    end
                end
                PH_LITIDX_CONT: begin
                    res0.out_kind    = hpbp_pkg::KIND_LIT_START;
                    res0.field_index = fin_val;
                    res0.store_flag  = n_store;
                    n_phase = (fin_val == '0) ? PH_NAMELEN_FIRST : PH_VALLEN_FIRST;
                end
                default: begin
                    res0.out_kind      = (fin_ctx == PH_NAMELEN_CONT)
                                         ? hpbp_pkg::KIND_NAME_START
                                         : hpbp_pkg::KIND_VAL_START;
                    res0.string_length = fin_val;
                    res0.huffman_flag  = n_huff;
                    n_remain           = fin_val;
                    if (fin_ctx == PH_NAMELEN_CONT) begin
                        n_phase = (fin_val == '0) ? PH_VALLEN_FIRST : PH_NAME_BYTES;
                    end else begin
                        n_phase = (fin_val == '0) ? PH_IDLE : PH_VAL_BYTES;
                    end
                end
            endcase
        end

        if (i_block_end) begin
            v1 = 1'b1;
            if (n_phase == PH_IDLE || n_phase == PH_ERROR) begin
                res1.out_kind = hpbp_pkg::KIND_DONE;
            end else begin
                res1.out_kind   = hpbp_pkg::KIND_ERROR;
                res1.error_code = hpbp_pkg::ERR_TRUNCATED;
            end
            n_phase  = PH_IDLE;
            n_acc    = '0;
            n_shift  = '0;
            n_cnt    = '0;
            n_remain = '0;
            n_store  = 1'b0;
            n_huff   = 1'b0;
        end
    end

    always_comb begin
        o_push.valid  = {v1, v0} & {2{i_accept}};
        o_push.res[0] = res0;
        o_push.res[1] = res1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_acc    <= '0;
            r_shift  <= '0;
            r_cnt    <= '0;
            r_remain <= '0;
            r_store  <= 1'b0;
            r_huff   <= 1'b0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_acc    <= n_acc;
            r_shift  <= n_shift;
            r_cnt    <= n_cnt;
            r_remain <= n_remain;
            r_store  <= n_store;
            r_huff   <= n_huff;
        end
    end

endmodule

// File: rtl/hpbp_fifo.sv
module hpbp_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hpbp_pkg::t_push     i_push,
    output logic                o_room,
    output logic                o_valid,
    input  logic                i_ready,
    output hpbp_pkg::t_result   o_result
);

    hpbp_pkg::t_result r_mem [hpbp_pkg::FIFO_DEPTH];
    logic [hpbp_pkg::PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [hpbp_pkg::PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [hpbp_pkg::CNT_W-1:0] r_count, n_count;

    hpbp_pkg::t_result first;
    logic [1:0]  num_wr;
    logic        pop;
    logic [hpbp_pkg::PTR_W-1:0] wr_ptr_next;

    always_comb begin
        first       = i_push.valid[0] ? i_push.res[0] : i_push.res[1];
        num_wr      = 2'(i_push.valid[0]) + 2'(i_push.valid[1]);
        pop         = o_valid && i_ready;
        wr_ptr_next = r_wr_ptr + hpbp_pkg::PTR_W'(1);
        n_wr_ptr    = r_wr_ptr + hpbp_pkg::PTR_W'(num_wr);
        n_rd_ptr    = r_rd_ptr + hpbp_pkg::PTR_W'(pop);
        n_count     = r_count + hpbp_pkg::CNT_W'(num_wr) - hpbp_pkg::CNT_W'(pop);
    end

    assign o_room   = (r_count <= hpbp_pkg::CNT_W'(hpbp_pkg::FIFO_DEPTH - 2));
    assign o_valid  = (r_count != '0);
    assign o_result = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (num_wr != 2'd0) begin
            r_mem[r_wr_ptr] <= first;
        end
        if (num_wr == 2'd2) begin
            r_mem[wr_ptr_next] <= i_push.res[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule
